// ----- design/omb_pkg.sv -----
// types, constants and single-precision helper functions for the ortho matrix builder
package omb_pkg;

	typedef logic [31:0] f32_t;

	// unpacked operand, significand normalized with its leading one at bit 23
	typedef struct packed {
		logic               sgn;
		logic signed [11:0] e;
		logic [23:0]        sig;
		logic               zero;
		logic               inf;
		logic               nan;
	} unp_t;

	// unrounded result, leading one at bit 25, value m * 2^(e-25)
	typedef struct packed {
		logic               sgn;
		logic signed [11:0] e;
		logic [25:0]        m;
		logic               stk;
		logic               zero;
		logic               inf;
		logic               nan;
	} rnd_t;

	// adder after alignment and add
	typedef struct packed {
		logic        sgn;
		logic [7:0]  be;
		logic [27:0] sum;
		logic        inf;
		logic        nan;
	} add_t;

	// divider lane state
	typedef struct packed {
		logic               sgn;
		logic signed [11:0] e;
		logic [23:0]        mb;
		logic [24:0]        rem;
		logic [26:0]        q;
		logic               zero;
		logic               inf;
		logic               nan;
	} div_t;

	// multiplier lane after the product
	typedef struct packed {
		logic               sgn;
		logic signed [11:0] e;
		logic [47:0]        prod;
		logic               zero;
		logic               inf;
		logic               nan;
	} mul_t;

	localparam f32_t F_QNAN = 32'h7FC00000;
	localparam f32_t F_TWO  = 32'h40000000;
	localparam f32_t F_MTWO = 32'hC0000000;
	localparam f32_t F_MIN_INT = 32'hCF000000; // -2^31

	localparam int LANES      = 6;
	localparam int ENTRIES    = 7;
	localparam int DIV_BITS   = 27;
	localparam int DIV_PER    = 3;
	localparam int DIV_STAGES = DIV_BITS / DIV_PER;

	// stage numbers
	localparam int ST_ADD  = 1;
	localparam int ST_NRM  = 2;
	localparam int ST_SUM  = 3;
	localparam int ST_DIV0 = 4;
	localparam int ST_QUO  = ST_DIV0 + DIV_STAGES + 1;
	localparam int ST_MU   = ST_QUO + 1;
	localparam int ST_MP   = ST_MU + 1;
	localparam int ST_ENT  = ST_MP + 1;
	localparam int STAGES  = ST_ENT + 1;

	function automatic logic [4:0] lead28(input logic [27:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 28; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	function automatic unp_t unpack(input f32_t x);
		logic [7:0]  ex;
		logic [7:0]  be;
		logic [23:0] raw;
		logic [4:0]  p;
		unp_t        u;
		ex     = x[30:23];
		raw    = {ex != 8'd0, x[22:0]};
		p      = lead28({4'b0, raw});
		be     = (ex == 8'd0) ? 8'd1 : ex;
		u.sgn  = x[31];
		u.nan  = (ex == 8'hFF) && (x[22:0] != 23'd0);
		u.inf  = (ex == 8'hFF) && (x[22:0] == 23'd0);
		u.zero = (x[30:0] == 31'd0);
		u.sig  = raw << (5'd23 - p);
		u.e    = $signed({4'b0, be}) - 12'sd150 + $signed({7'b0, p});
		return u;
	endfunction

	// round to nearest even, handles subnormal results and overflow
	function automatic f32_t round_pack(input rnd_t r);
		logic signed [11:0] be;
		logic [11:0]        shv;
		logic [4:0]         sh;
		logic [51:0]        wide;
		logic [25:0]        mm;
		logic [23:0]        sig;
		logic               nrm;
		logic               g;
		logic               st;
		logic               inc;
		logic [30:0]        word;
		f32_t               res;
		be   = r.e + 12'sd127;
		nrm  = (be > 12'sd0);
		shv  = 12'(12'sd1 - be);
		sh   = nrm ? 5'd0 : ((shv > 12'd27) ? 5'd27 : shv[4:0]);
		wide = {r.m, 26'b0} >> sh;
		mm   = wide[51:26];
		sig  = mm[25:2];
		g    = mm[1];
		st   = mm[0] | r.stk | (|wide[25:0]);
		inc  = g & (st | sig[0]);
		word = {(nrm ? be[7:0] : 8'd0), sig[22:0]} + {30'b0, inc};
		if (r.nan) begin
			res = F_QNAN;
		end else if (r.inf || (nrm && be > 12'sd254)) begin
			res = {r.sgn, 8'hFF, 23'b0};
		end else if (r.zero) begin
			res = {r.sgn, 31'b0};
		end else begin
			res = {r.sgn, word};
		end
		return res;
	endfunction

	// adder front: order by magnitude, align with sticky, add or subtract
	function automatic add_t add_front(input f32_t a, input f32_t b);
		logic        swap;
		f32_t        x;
		f32_t        y;
		logic [7:0]  bex;
		logic [7:0]  bey;
		logic [7:0]  d;
		logic [26:0] ext_x;
		logic [26:0] ext_y;
		logic [26:0] al;
		logic [26:0] mask;
		logic        sub;
		logic        ainf;
		logic        binf;
		logic        anan;
		logic        bnan;
		add_t        o;
		swap  = (b[30:0] > a[30:0]);
		x     = swap ? b : a;
		y     = swap ? a : b;
		bex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		bey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d     = bex - bey;
		ext_x = {x[30:23] != 8'd0, x[22:0], 3'b0};
		ext_y = {y[30:23] != 8'd0, y[22:0], 3'b0};
		if (d >= 8'd27) begin
			al = {26'b0, ext_y != 27'd0};
		end else begin
			mask  = (27'd1 << d) - 27'd1;
			al    = ext_y >> d;
			al[0] = al[0] | (|(ext_y & mask));
		end
		sub   = x[31] ^ y[31];
		o.sum = sub ? ({1'b0, ext_x} - {1'b0, al}) : ({1'b0, ext_x} + {1'b0, al});
		anan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bnan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ainf  = (a[30:0] == 31'h7F800000);
		binf  = (b[30:0] == 31'h7F800000);
		o.nan = anan | bnan | (ainf & binf & sub);
		o.inf = ainf | binf;
		o.be  = bex;
		// exact cancellation gives +0, two zeros of one sign keep it
		o.sgn = (o.sum == 28'd0 && !o.inf) ? (a[31] & b[31]) : x[31];
		return o;
	endfunction

	function automatic rnd_t add_norm(input add_t a);
		logic [4:0]  p;
		logic [27:0] norm;
		rnd_t        r;
		p      = lead28(a.sum);
		norm   = a.sum << (5'd27 - p);
		r.sgn  = a.sgn;
		r.m    = norm[27:2];
		r.stk  = |norm[1:0];
		r.e    = $signed({4'b0, a.be}) - 12'sd153 + $signed({7'b0, p});
		r.zero = (a.sum == 28'd0);
		r.inf  = a.inf;
		r.nan  = a.nan;
		return r;
	endfunction

	// exact multiply by 65536
	function automatic rnd_t scale16(input unp_t u);
		rnd_t r;
		r.sgn  = u.sgn;
		r.e    = u.e + 12'sd16;
		r.m    = {u.sig, 2'b0};
		r.stk  = 1'b0;
		r.zero = u.zero;
		r.inf  = u.inf;
		r.nan  = u.nan;
		return r;
	endfunction

	function automatic div_t div_init(input f32_t a, input f32_t b);
		unp_t ua;
		unp_t ub;
		div_t d;
		ua     = unpack(a);
		ub     = unpack(b);
		d.sgn  = ua.sgn ^ ub.sgn;
		d.e    = ua.e - ub.e;
		d.mb   = ub.sig;
		d.rem  = {1'b0, ua.sig};
		d.q    = '0;
		d.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
		d.inf  = ua.inf | ub.zero;
		d.zero = ua.zero | ub.inf;
		return d;
	endfunction

	// restoring division, DIV_PER quotient bits
	function automatic div_t div_step(input div_t din);
		div_t        d;
		logic        ge;
		logic [24:0] diff;
		d = din;
		for (int i = 0; i < DIV_PER; i++) begin
			ge    = (d.rem >= {1'b0, d.mb});
			diff  = ge ? (d.rem - {1'b0, d.mb}) : d.rem;
			d.rem = {diff[23:0], 1'b0};
			d.q   = {d.q[25:0], ge};
		end
		return d;
	endfunction

	function automatic rnd_t div_fin(input div_t d);
		rnd_t r;
		r.sgn  = d.sgn;
		r.zero = d.zero;
		r.inf  = d.inf;
		r.nan  = d.nan;
		if (d.q[26]) begin
			r.m   = d.q[26:1];
			r.stk = d.q[0] | (d.rem != 25'd0);
			r.e   = d.e;
		end else begin
			r.m   = d.q[25:0];
			r.stk = (d.rem != 25'd0);
			r.e   = d.e - 12'sd1;
		end
		return r;
	endfunction

	function automatic mul_t mul_prod(input unp_t ua, input unp_t ub);
		mul_t m;
		m.sgn  = ua.sgn ^ ub.sgn;
		m.e    = ua.e + ub.e;
		m.prod = ua.sig * ub.sig;
		m.nan  = ua.nan | ub.nan | (ua.zero & ub.inf) | (ua.inf & ub.zero);
		m.inf  = ua.inf | ub.inf;
		m.zero = ua.zero | ub.zero;
		return m;
	endfunction

	function automatic rnd_t mul_fin(input mul_t m);
		rnd_t r;
		r.sgn  = m.sgn;
		r.zero = m.zero;
		r.inf  = m.inf;
		r.nan  = m.nan;
		if (m.prod[47]) begin
			r.m   = m.prod[47:22];
			r.stk = |m.prod[21:0];
			r.e   = m.e + 12'sd1;
		end else begin
			r.m   = m.prod[46:21];
			r.stk = |m.prod[20:0];
			r.e   = m.e;
		end
		return r;
	endfunction

	// float to int32 by truncation, {overflow, value}; s15.16 once prescaled by 2^16
	function automatic logic [32:0] to_fixed(input f32_t x);
		logic [7:0]  ex;
		logic [4:0]  sh;
		logic [54:0] tmp;
		logic [31:0] mag;
		logic [32:0] res;
		ex  = x[30:23];
		sh  = 5'(ex - 8'd127);
		tmp = {31'b0, 1'b1, x[22:0]} << sh;
		mag = tmp[54:23];
		if (ex == 8'hFF && x[22:0] != 23'd0) begin
			res = {1'b1, 32'd0};
		end else if (x == F_MIN_INT) begin
			res = {1'b0, 32'h80000000};
		end else if (ex >= 8'd158) begin
			res = {1'b1, (x[31] ? 32'h80000000 : 32'h7FFFFFFF)};
		end else if (ex < 8'd127) begin
			res = '0;
		end else begin
			res = {1'b0, (x[31] ? (~mag + 32'd1) : mag)};
		end
		return res;
	endfunction

endpackage

// ----- design/ortho_matrix_fixed_builder.sv -----
// ortho matrix builder: single-precision pipeline from plane set to s15.16 entries
//
// one input transaction on s_axis carries seven single-precision bit patterns
// (left, right, bottom, top, near, far, gain); one output transaction on m_axis
// carries the seven nonzero entries of the orthographic matrix in s15.16 and an
// overflow flag. every input transaction gives exactly one output transaction.
// eighteen register stages; a new transaction can be taken every cycle while
// the receiver keeps m_axis_tready high. the chain is: align/add, normalize,
// round sums, divider setup, nine divider stages of three quotient bits each
// (the divider sets the depth), round quotients, multiplier setup, 24x24
// product, round products, fixed-point conversion into the output register.
// each stage holds its own valid bit and moves when the next stage is empty or
// moving, so a stalled receiver backs the pipeline up one stage at a time and
// s_axis_tready only drops once every stage is full. nothing is lost or repeated.
// reset clears the valid bits; no other state is kept between transactions.
module ortho_matrix_fixed_builder
	import omb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// left_bits, right_bits, bottom_bits, top_bits, near_bits, far_bits, gain_bits
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// entry_xx, entry_yy, entry_zz, offset_x, offset_y, offset_z, entry_ww,
	// overflow, zero fill
	output logic [231:0] m_axis_tdata
);

	logic [STAGES:1]   vld_s;
	logic [STAGES+1:1] adv;

	f32_t in_f [ENTRIES];

	add_t add_s1  [LANES];
	unp_t gain_s1;
	rnd_t sum_s2  [LANES];
	f32_t gain_s2;
	f32_t sum_s3  [LANES];
	f32_t gain_s3;
	// divider lanes, index k sits in stage ST_DIV0 + k
	div_t div_pipe_s  [DIV_STAGES+1][LANES];
	f32_t gain_pipe_s [DIV_STAGES+1];
	f32_t quo_s14 [LANES];
	f32_t gain_s14;
	unp_t qu_s15  [LANES];
	unp_t gu_s15;
	f32_t gain_s15;
	mul_t prod_s16 [LANES];
	f32_t gain_s16;
	f32_t ent_s17 [ENTRIES];
	logic [31:0] fix_s18 [ENTRIES];
	logic        ovf_s18;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			in_f[i] = s_axis_tdata[32*i +: 32];
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[STAGES+1] = m_axis_tready;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_s[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// sums: lanes 0..2 are r-l, t-b, f-n, lanes 3..5 are r+l, t+b, f+n
	always_ff @(posedge clk) begin
		if (adv[ST_ADD]) begin
			for (int i = 0; i < LANES; i++) begin
				add_s1[i] <= add_front(in_f[2*(i%3)+1],
					in_f[2*(i%3)] ^ {(i < 3), 31'b0});
			end
			gain_s1 <= unpack(in_f[6]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_NRM]) begin
			for (int i = 0; i < LANES; i++) begin
				sum_s2[i] <= add_norm(add_s1[i]);
			end
			gain_s2 <= round_pack(scale16(gain_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SUM]) begin
			for (int i = 0; i < LANES; i++) begin
				sum_s3[i] <= round_pack(sum_s2[i]);
			end
			gain_s3 <= gain_s2;
		end
	end

	// numerators: 2, 2, -2, then the negated sums
	always_ff @(posedge clk) begin
		if (adv[ST_DIV0]) begin
			for (int i = 0; i < LANES; i++) begin
				div_pipe_s[0][i] <= div_init(
					(i < 3) ? ((i == 2) ? F_MTWO : F_TWO) : (sum_s3[i] ^ 32'h80000000),
					sum_s3[i%3]);
			end
			gain_pipe_s[0] <= gain_s3;
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[ST_DIV0+k]) begin
				for (int i = 0; i < LANES; i++) begin
					div_pipe_s[k][i] <= div_step(div_pipe_s[k-1][i]);
				end
				gain_pipe_s[k] <= gain_pipe_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_QUO]) begin
			for (int i = 0; i < LANES; i++) begin
				quo_s14[i] <= round_pack(div_fin(div_pipe_s[DIV_STAGES][i]));
			end
			gain_s14 <= gain_pipe_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_MU]) begin
			for (int i = 0; i < LANES; i++) begin
				qu_s15[i] <= unpack(quo_s14[i]);
			end
			gu_s15   <= unpack(gain_s14);
			gain_s15 <= gain_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_MP]) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s16[i] <= mul_prod(qu_s15[i], gu_s15);
			end
			gain_s16 <= gain_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_ENT]) begin
			for (int i = 0; i < LANES; i++) begin
				ent_s17[i] <= round_pack(mul_fin(prod_s16[i]));
			end
			ent_s17[LANES] <= gain_s16;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		logic [32:0] cv;
		logic        ov;
		if (adv[STAGES]) begin
			ov = 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				cv         = to_fixed(ent_s17[i]);
				fix_s18[i] <= cv[31:0];
				ov         = ov | cv[32];
			end
			ovf_s18 <= ov;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			m_axis_tdata[32*i +: 32] = fix_s18[i];
		end
		m_axis_tdata[32*ENTRIES] = ovf_s18;
	end

	// full pipeline with a stalled receiver takes nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s == '1 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while every stage is full");

	// an empty first stage always accepts
	assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[1] |-> s_axis_tready)
		else $error("empty first stage refused a transaction");

	// 2^31-1 is not a single-precision value, so it only comes from saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (fix_s18[LANES] == 32'h7FFFFFFF || fix_s18[0] == 32'h7FFFFFFF))
		|-> ovf_s18)
		else $error("saturated entry without overflow flag");

endmodule

// ----- dv/ortho_matrix_fixed_builder_test.sv -----
// self-checking testbench for ortho_matrix_fixed_builder with a single-precision predictor
module ortho_matrix_fixed_builder_test;
	import omb_pkg::*;

	localparam logic [31:0] SIGN_BIT = 32'h80000000;
	localparam int          STALL_AT = 120;  // result count where the receiver holds off
	localparam int          STALL_LEN = 80;  // well over the pipeline depth
	localparam int          PAUSE_AT = 400;  // item count where the sender drains
	localparam int          QUIET_AT = 800;  // no idling past this many items

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [231:0] m_axis_tdata;

	logic [223:0] plane_sets[$];    // parameter sets waiting to be driven
	logic [224:0] matrix_due[$];    // predicted entries and overflow, oldest first
	int           errors;
	int           sent;
	int           got;
	bit           in_taken;
	bit           drained;
	int           src_gap;
	int           sink_gap;
	int           sink_hold;
	bit           hold_done;
	bit           stim_done;

	ortho_matrix_fixed_builder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------- single-precision arithmetic on bit patterns ----------------

	function automatic bit is_nan(input logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 23'd0;
	endfunction

	function automatic bit is_inf(input logic [31:0] x);
		return x[30:0] == 31'h7F800000;
	endfunction

	function automatic bit is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// exact widening of a finite single to a double
	function automatic real single_to_real(input logic [31:0] x);
		real v;
		if (x[30:23] == 8'd0) begin
			v = real'(x[22:0]) * 2.0 ** (-149);
			return x[31] ? -v : v;
		end
		return $bitstoreal({x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'b0});
	endfunction

	// round a double to single with nearest-even, subnormals and overflow
	function automatic logic [31:0] round_to_single(input real v);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] kept;
		longint      word;
		int          be;
		int          sh;
		bit          g;
		bit          st;
		d = $realtobits(v);
		if (d[62:0] == 63'd0)
			return {d[63], 31'd0};
		be = int'(d[62:52]) - 1023 + 127;
		m  = {11'd0, 1'b1, d[51:0]};
		sh = (be >= 1) ? 29 : 29 + 1 - be;
		if (sh > 60)
			sh = 60;
		kept = m >> sh;
		g    = m[sh-1];
		st   = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
		if (be >= 1)
			word = longint'(be) * 8388608 + longint'(kept[22:0]);
		else
			word = longint'(kept);
		if (g && (st || kept[0]))
			word = word + 1;
		if (word >= 64'h7F800000)
			return {d[63], 31'h7F800000};
		return {d[63], word[30:0]};
	endfunction

	function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
		real s;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
			return F_QNAN;
		if (is_inf(a))
			return a;
		if (is_inf(b))
			return b;
		s = single_to_real(a) + single_to_real(b);
		// exact cancellation is +0 unless both addends are -0
		if (s == 0.0)
			return {a[31] & b[31], 31'd0};
		return round_to_single(s);
	endfunction

	function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
		logic sg;
		sg = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
			return F_QNAN;
		if (is_inf(a) || is_inf(b))
			return {sg, 31'h7F800000};
		if (is_zero(a) || is_zero(b))
			return {sg, 31'd0};
		return round_to_single(single_to_real(a) * single_to_real(b));
	endfunction

	function automatic logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
		logic sg;
		sg = a[31] ^ b[31];
		if (is_zero(b))
			return (is_nan(a) || is_zero(a)) ? F_QNAN : {sg, 31'h7F800000};
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b)))
			return F_QNAN;
		if (is_inf(a))
			return {sg, 31'h7F800000};
		if (is_inf(b) || is_zero(a))
			return {sg, 31'd0};
		return round_to_single(single_to_real(a) / single_to_real(b));
	endfunction

	// integer part by truncation, s15.16 once prescaled by 2^16; flag set on saturation or NaN
	function automatic logic [32:0] fixed_of(input logic [31:0] x);
		real v;
		if (is_nan(x))
			return {1'b1, 32'd0};
		if (is_inf(x))
			return {1'b1, x[31] ? 32'h80000000 : 32'h7FFFFFFF};
		v = single_to_real(x);
		if (v >= 2147483648.0)
			return {1'b1, 32'h7FFFFFFF};
		if (v < -2147483648.0)
			return {1'b1, 32'h80000000};
		return {1'b0, 32'($rtoi(v))};
	endfunction

	function automatic logic [224:0] ortho_entries(input logic [223:0] p);
		logic [31:0] l, r, b, t, n, f, s, rl, tb, fn;
		logic [31:0] ent[7];
		logic [32:0] fx;
		logic [224:0] res;
		l  = p[31:0];
		r  = p[63:32];
		b  = p[95:64];
		t  = p[127:96];
		n  = p[159:128];
		f  = p[191:160];
		s  = f_mul(p[223:192], 32'h47800000);  // times 65536
		rl = f_add(r, l ^ SIGN_BIT);
		tb = f_add(t, b ^ SIGN_BIT);
		fn = f_add(f, n ^ SIGN_BIT);
		ent[0] = f_mul(f_div(F_TWO, rl), s);
		ent[1] = f_mul(f_div(F_TWO, tb), s);
		ent[2] = f_mul(f_div(F_MTWO, fn), s);
		ent[3] = f_mul(f_div(f_add(r, l) ^ SIGN_BIT, rl), s);
		ent[4] = f_mul(f_div(f_add(t, b) ^ SIGN_BIT, tb), s);
		ent[5] = f_mul(f_div(f_add(f, n) ^ SIGN_BIT, fn), s);
		ent[6] = s;
		res = '0;
		for (int i = 0; i < 7; i++) begin
			fx = fixed_of(ent[i]);
			res[32*i +: 32] = fx[31:0];
			res[224] = res[224] | fx[32];
		end
		return res;
	endfunction

	// ---------------- stimulus ----------------

	// mostly moderate magnitudes, with raw patterns and specials mixed in
	function automatic logic [31:0] rand_plane();
		int k;
		k = $urandom_range(0, 19);
		if (k < 12)
			return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		if (k < 15)
			return $urandom;
		if (k == 15)
			return {1'($urandom), 8'($urandom_range(0, 1)), 23'($urandom)};
		if (k == 16)
			return {1'($urandom), 31'h7F800000};
		if (k == 17)
			return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
		if (k == 18)
			return {1'($urandom), 31'd0};
		return {1'($urandom), 8'($urandom_range(140, 254)), 23'($urandom)};
	endfunction

	task automatic add_set(input logic [31:0] l, r, b, t, n, f, g);
		plane_sets.push_back({g, f, n, t, b, r, l});
	endtask

	initial begin
		logic [31:0] v[7];
		errors = 0;
		// ordinary frustum
		add_set(32'hC0800000, 32'h40800000, 32'hC0400000, 32'h40400000,
			32'h3DCCCCCD, 32'h42C80000, 32'h3F800000);
		// planes that coincide: zero divisors with nonzero numerators
		add_set(32'h3F800000, 32'h3F800000, 32'h40000000, 32'h40000000,
			32'h40400000, 32'h40400000, 32'h3F800000);
		// all planes zero: zero over zero gives NaN, signed zeros in play
		add_set(32'h80000000, 32'h00000000, 32'h00000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'hBF800000);
		// gain -32768: entries of exactly -2^31 do not saturate, but entry_zz is 2^31 and flags overflow
		add_set(32'hBF800000, 32'h3F800000, 32'hBF800000, 32'h3F800000,
			32'hBF800000, 32'h3F800000, 32'hC7000000);
		// gain 32768: exactly 2^31 saturates positive
		add_set(32'hBF800000, 32'h3F800000, 32'hBF800000, 32'h3F800000,
			32'hBF800000, 32'h3F800000, 32'h47000000);
		// largest finite gain and planes, tiny subnormal gain
		add_set(32'hFF7FFFFF, 32'h7F7FFFFF, 32'h00000001, 32'h80000001,
			32'h00800000, 32'h7F7FFFFF, 32'h7F7FFFFF);
		add_set(32'hFF7FFFFF, 32'h7F7FFFFF, 32'h00000001, 32'h80000001,
			32'h00800000, 32'h7F7FFFFF, 32'h00000001);
		// infinities and NaNs among the planes and as the gain
		add_set(32'hFF800000, 32'h7F800000, 32'h7F800000, 32'h7F800000,
			32'h7FC00000, 32'h3F800000, 32'h3F800000);
		add_set(32'h00000000, 32'h3F800000, 32'h00000000, 32'h3F800000,
			32'h00000000, 32'h3F800000, 32'h7F800000);
		add_set(32'h00000000, 32'h3F800000, 32'h00000000, 32'h3F800000,
			32'h00000000, 32'h3F800000, 32'hFFFFFFFF);
		add_set(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_set(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
			32'h00000000, 32'h00000000, 32'h00000000);
		// small gain: entries truncate toward zero from both sides
		add_set(32'hC0A00000, 32'h3F800000, 32'h40A00000, 32'hBF800000,
			32'h41200000, 32'h3F000000, 32'h37800001);
		for (int i = 0; i < 900; i++) begin
			for (int j = 0; j < 7; j++)
				v[j] = rand_plane();
			// keep the gain mostly modest so entries are usually in range
			if ($urandom_range(0, 3) != 0)
				v[6] = {1'($urandom), 8'($urandom_range(100, 135)), 23'($urandom)};
			add_set(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
		end
		stim_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// sample both handshakes at the rising edge; inputs only move at the falling edge
	always @(posedge clk) begin
		logic [224:0] want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			matrix_due.push_back(ortho_entries(s_axis_tdata));
		if (m_axis_tvalid && m_axis_tready) begin
			got <= got + 1;
			if (matrix_due.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = matrix_due.pop_front();
				for (int i = 0; i < 7; i++) begin
					if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) begin
						$display("%0t: entry %0d expected %h actual %h", $time, i,
							want[32*i +: 32], m_axis_tdata[32*i +: 32]);
						errors++;
					end
				end
				if (m_axis_tdata[224] !== want[224]) begin
					$display("%0t: overflow expected %b actual %b", $time, want[224],
						m_axis_tdata[224]);
					errors++;
				end
			end
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		in_taken  = 1'b0;
		drained   = 1'b0;
		hold_done = 1'b0;
		sent = 0;
		got = 0;
		src_gap = 0;
		sink_gap = 0;
		sink_hold = 0;
	end

	// sender: holds a transaction until taken, then idles in bursts or moves on
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sent == PAUSE_AT && !drained) begin
				// drain the pipeline completely once mid-run
				s_axis_tvalid <= 1'b0;
				if (matrix_due.size() == 0 && !m_axis_tvalid)
					drained <= 1'b1;
			end else if (plane_sets.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (sent < QUIET_AT && $urandom_range(0, 7) == 0) begin
				src_gap <= $urandom_range(0, 18);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tdata  <= plane_sets.pop_front();
				s_axis_tvalid <= 1'b1;
				sent <= sent + 1;
			end
		end
	end

	// receiver: one long hold-off to back the pipeline up, else random bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (got >= STALL_AT && !hold_done) begin
			hold_done <= 1'b1;
			sink_hold <= STALL_LEN;
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (sent < QUIET_AT && $urandom_range(0, 9) == 0) begin
			sink_gap <= $urandom_range(0, 18);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		wait (stim_done && arst_n);
		while (plane_sets.size() != 0 || s_axis_tvalid || matrix_due.size() != 0)
			@(posedge clk);
		// let any stray result show up past the pipeline depth
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("ortho_matrix_fixed_builder test passed");
		else
			$display("ortho_matrix_fixed_builder test failed");
		$finish;
	end

	initial begin
		#600000;
		$display("ortho_matrix_fixed_builder test failed");
		$finish;
	end

endmodule
